@@ rtl/spq_pkg.sv @@
// Shared types and constants of the sorted priority queue.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_W = 32;
	localparam int POS_W = 4;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_FIND = 2'd2,
		OP_NOP = 2'd3
	} spq_op_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic signed [KEY_W-1:0] value;
	} spq_req_t;

	typedef struct packed {
		logic success;
		logic [POS_W-1:0] position;
		logic [COUNT_W-1:0] count;
		logic signed [KEY_W-1:0] head_value;
		logic empty_res;
		logic full_res;
	} spq_res_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} spq_ctl_t;

endpackage

@@ rtl/spq_cell.sv @@
// One storage cell of the sorted chain: compares against the request key and shifts.
module spq_cell import spq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input spq_ctl_t ctl,
	input logic signed [KEY_W-1:0] key,
	input logic left_gt,
	input logic signed [KEY_W-1:0] left_entry,
	input logic left_valid,
	input logic signed [KEY_W-1:0] right_entry,
	input logic right_valid,
	output logic signed [KEY_W-1:0] entry,
	output logic valid,
	output logic gt,
	output logic bnd,
	output logic hit
);

	logic signed [KEY_W-1:0] entry_q;
	logic valid_q;

	// The chain is sorted, so the cells holding keys above the request form a prefix.
	assign gt = valid_q && (entry_q > key);
	assign bnd = !gt && left_gt;
	assign hit = bnd && valid_q && (entry_q == key);
	assign entry = entry_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins && !gt) begin
			valid_q <= valid_q | left_valid;
		end else if (ctl.rem && !gt) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && !gt) begin
			entry_q <= bnd ? key : left_entry;
		end else if (ctl.rem && !gt) begin
			entry_q <= right_entry;
		end
	end

endmodule

@@ rtl/sorted_priority_queue_top.sv @@
// Top level of the sorted priority queue: a chain of compare-and-shift cells.
// The queue keeps up to CAPACITY signed keys in descending order, one per cell, and
// takes one request per clock cycle: busy stays low. Each request is compared against
// every cell at once and the chain shifts by one place on an insert into a non-full
// queue or a successful remove, so the result appears on res with done high in the
// cycle after start, and the count, head value and flags in it already reflect that
// request. The receiver cannot stall; a result is present for exactly one cycle.
module sorted_priority_queue_top import spq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input spq_req_t req,
	output logic busy,
	output logic done,
	output spq_res_t res
);

	logic signed [KEY_W-1:0] entry_w [CAPACITY];
	logic valid_w [CAPACITY];
	logic gt_w [CAPACITY];
	logic [CAPACITY-1:0] bnd_w;
	logic [CAPACITY-1:0] hit_w;
	spq_ctl_t ctl;
	logic accept;
	logic full;
	logic any_hit;
	logic [IDX_W-1:0] bnd_idx;
	logic [CNT_W-1:0] count_q;
	logic done_q;
	logic success_q;
	logic [IDX_W-1:0] pos_q;

	assign busy = 1'b0;
	assign accept = start && !busy;
	assign full = (count_q == CNT_W'(CAPACITY));
	assign any_hit = |hit_w;

	always_comb begin
		bnd_idx = '0;
		for (int b = 0; b < IDX_W; b++) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (((i >> b) & 1) == 1) begin
					bnd_idx[b] = bnd_idx[b] | bnd_w[i];
				end
			end
		end
	end

	always_comb begin
		ctl.ins = accept && (req.opcode == OP_INSERT) && !full;
		ctl.rem = accept && (req.opcode == OP_REMOVE) && any_hit;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic left_gt;
		logic signed [KEY_W-1:0] left_entry;
		logic left_valid;
		logic signed [KEY_W-1:0] right_entry;
		logic right_valid;

		if (i == 0) begin : g_first
			assign left_gt = 1'b1;
			assign left_entry = req.value;
			assign left_valid = 1'b1;
		end else begin : g_mid
			assign left_gt = gt_w[i-1];
			assign left_entry = entry_w[i-1];
			assign left_valid = valid_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = '0;
			assign right_valid = 1'b0;
		end else begin : g_inner
			assign right_entry = entry_w[i+1];
			assign right_valid = valid_w[i+1];
		end

		spq_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.key(req.value),
			.left_gt(left_gt),
			.left_entry(left_entry),
			.left_valid(left_valid),
			.right_entry(right_entry),
			.right_valid(right_valid),
			.entry(entry_w[i]),
			.valid(valid_w[i]),
			.gt(gt_w[i]),
			.bnd(bnd_w[i]),
			.hit(hit_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctl.rem) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (req.opcode)
				OP_INSERT: begin
					success_q <= !full;
					pos_q <= full ? '0 : bnd_idx;
				end
				OP_REMOVE, OP_FIND: begin
					success_q <= any_hit;
					pos_q <= any_hit ? bnd_idx : '0;
				end
				default: begin
					success_q <= 1'b0;
					pos_q <= '0;
				end
			endcase
		end
	end

	assign done = done_q;

	always_comb begin
		res.success = success_q;
		res.position = POS_W'(pos_q);
		res.count = COUNT_W'(count_q);
		res.head_value = valid_w[0] ? entry_w[0] : '0;
		res.empty_res = (count_q == '0);
		res.full_res = full;
	end

endmodule

@@ rtl/spq_checker.sv @@
// Port-level checker of the sorted priority queue, bound to the top level.
module spq_checker import spq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input spq_req_t req,
	input logic busy,
	input logic done,
	input spq_res_t res
);

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("request did not produce a result in the next cycle");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |=> !done)
		else $error("result without a request");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.empty_res) |-> (res.head_value == '0 && res.count == '0 && !res.success
			|| res.head_value == '0 && res.count == '0 && $past(req.opcode) == OP_REMOVE))
		else $error("empty queue reports a head value or a count");

	a_fail_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.success) |-> (res.position == '0))
		else $error("failed request reports a position");

	a_full_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(done && res.full_res) |-> (!res.empty_res && res.count == COUNT_W'(CAPACITY)))
		else $error("full flag disagrees with the count");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.req(req),
	.busy(busy),
	.done(done),
	.res(res)
);
